// ===== rtl/core/cft_pkg.sv =====
`default_nettype none
package cft_pkg;

  localparam int MAX_SEP_LEN       = 4;
  localparam int FIELD_COUNT_WIDTH = 16;
  localparam int LA_CAP            = MAX_SEP_LEN + 2;
  localparam int TOK_MAX           = MAX_SEP_LEN + 1;
  localparam int LEN_W             = $clog2(LA_CAP + 1);
  localparam int RES_MAX           = 8;
  localparam int RCNT_W            = $clog2(RES_MAX + 1);
  localparam int QDEPTH            = 4;
  localparam int QPTR_W            = $clog2(QDEPTH);
  localparam int QCNT_W            = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 32;
  localparam int NTOK              = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_SEP_BYTES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_SEP_LEN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_SEP_BYTES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_SEP_LEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTE_BYTE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_CHECK      = 3'd5;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_FIELD  = 2'd1,
    KIND_RECORD = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_TRAIL    = 3'd1,
    ERR_QUOTE    = 3'd2,
    ERR_UNCLOSED = 3'd3,
    ERR_COUNT    = 3'd4
  } err_t;

  typedef enum logic [1:0] {
    MODE_REC_START   = 2'd0,
    MODE_FIELD_START = 2'd1,
    MODE_UNQUOTED    = 2'd2,
    MODE_QUOTED      = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ACT_REC   = 3'd0,
    ACT_FLD   = 3'd1,
    ACT_TRAIL = 3'd2,
    ACT_QERR  = 3'd3,
    ACT_QQ    = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RUN  = 2'd1,
    PH_REC  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    err_t       error_code;
    logic       in_header;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] field_sep_bytes;
    logic [2:0]  field_sep_len;
    logic [31:0] record_sep_bytes;
    logic [2:0]  record_sep_len;
    logic [7:0]  quote_byte;
    logic        count_check_enable;
  } cfg_t;

  typedef struct packed {
    err_t err;
    logic busy;
  } status_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [2:0] v);
    if (v == 3'd0) return LEN_W'(1);
    if (int'(v) > MAX_SEP_LEN) return LEN_W'(MAX_SEP_LEN);
    return LEN_W'(v);
  endfunction

  function automatic logic [7:0] sep_byte(input logic [31:0] b, input int i);
    if (i >= 0 && i < 4) return b[8*i +: 8];
    return 8'h00;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/csv_field_tokenizer.sv =====
// CSV field tokenizer.
// Input channel item_valid/item_stall/item: one byte per item, or an
// end_of_input mark. Output channel result_valid/result_stall/result: content
// bytes, end-of-field, end-of-record and error results; last marks the final
// result caused by an input item. Items that cause no result produce nothing.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle; write
// only while the block is idle.
// A four-entry input queue feeds a parse engine that performs at most one parse
// step per cycle (content byte, separator match, opening quote, record close) and
// emits at most one result per cycle into an output register.
// An item with one result passes it straight into the output register; with
// several, each result but the last first waits in a hold register, and when
// the last step emits a result while an earlier one is still held, the engine
// pushes the held one before it completes that step. A byte that waits in the
// lookahead window emits nothing until a later item resolves it. Sustained
// rate is one byte per cycle on ordinary content while result_stall is low.
// While result_stall is high the engine holds and the input queue fills, then
// item_stall rises. Reset empties the queue, the lookahead and the output
// register, restores the register defaults and clears any latched error.
`default_nettype none
module csv_field_tokenizer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  cft_pkg::in_item_t                item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output cft_pkg::out_item_t               result,
  input  logic                             cfg_we,
  input  logic [cft_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cft_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cft_pkg::*;

  cfg_t      cfg;
  logic      q_valid;
  in_item_t  q_item;
  logic      q_pop;
  logic      push_valid;
  out_item_t push_item;
  logic      push_ready;
  status_t   status;
  logic      o_valid;
  out_item_t o_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.field_sep_bytes    <= 32'd44;
      cfg.field_sep_len      <= 3'd1;
      cfg.record_sep_bytes   <= 32'd10;
      cfg.record_sep_len     <= 3'd1;
      cfg.quote_byte         <= 8'd34;
      cfg.count_check_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIELD_SEP_BYTES:  cfg.field_sep_bytes    <= cfg_data[31:0];
        CFG_FIELD_SEP_LEN:    cfg.field_sep_len      <= cfg_data[2:0];
        CFG_RECORD_SEP_BYTES: cfg.record_sep_bytes   <= cfg_data[31:0];
        CFG_RECORD_SEP_LEN:   cfg.record_sep_len     <= cfg_data[2:0];
        CFG_QUOTE_BYTE:       cfg.quote_byte         <= cfg_data[7:0];
        CFG_COUNT_CHECK:      cfg.count_check_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cft_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  cft_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .status     (status)
  );

  assign push_ready = !o_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (push_ready) begin
      o_valid <= push_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ready && push_valid) o_item <= push_item;
  end

  assign result_valid = o_valid;
  assign result       = o_item;

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (status.err != ERR_NONE) |=> (status.err == $past(status.err)))
    else $error("latched error changed");

  a_code_only_on_error: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind != KIND_ERROR) |-> (result.error_code == ERR_NONE))
    else $error("error code on a non-error result");

  a_byte_only_on_content: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind != KIND_BYTE) |-> (result.out_byte == 8'h00))
    else $error("byte on a non-content result");

  a_error_result_matches: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == KIND_ERROR) |-> (status.err == result.error_code))
    else $error("error result differs from latched code");

endmodule
`default_nettype wire

// ===== rtl/core/cft_front.sv =====
`default_nettype none
module cft_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  cft_pkg::in_item_t item,
  output logic              q_valid,
  output cft_pkg::in_item_t q_item,
  input  logic              q_pop
);
  import cft_pkg::*;

  in_item_t            slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                wr;
  logic                rd;

  assign item_stall = (count == QCNT_W'(QDEPTH));
  assign wr         = item_valid && !item_stall;
  assign rd         = q_pop && q_valid;
  assign q_valid    = (count != '0);
  assign q_item     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      if (wr && !rd) count <= count + 1'b1;
      else if (rd && !wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slots[wr_ptr] <= item;
  end

endmodule
`default_nettype wire

// ===== rtl/core/cft_engine.sv =====
`default_nettype none
module cft_engine (
  input  logic               clk,
  input  logic               rst,
  input  cft_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  cft_pkg::in_item_t  q_item,
  output logic               q_pop,
  output logic               push_valid,
  output cft_pkg::out_item_t push_item,
  input  logic               push_ready,
  output cft_pkg::status_t   status
);
  import cft_pkg::*;

  logic [7:0]                   la_buf [LA_CAP];
  logic [LEN_W-1:0]             cnt;
  mode_t                        mode;
  logic [FIELD_COUNT_WIDTH-1:0] fcount;
  logic [FIELD_COUNT_WIDTH-1:0] hcount;
  logic                         hpend;
  err_t                         err;
  phase_t                       phase;
  logic                         step_e;
  logic                         rec_final;
  logic [RCNT_W-1:0]            rcnt;
  logic                         h_valid;
  out_item_t                    h_res;

  logic [7:0]                   buf_next [LA_CAP];
  logic [LEN_W-1:0]             cnt_next;
  mode_t                        mode_next;
  logic [FIELD_COUNT_WIDTH-1:0] fcount_next;
  logic [FIELD_COUNT_WIDTH-1:0] fcount_inc;
  logic [FIELD_COUNT_WIDTH-1:0] hcount_next;
  logic                         hpend_next;
  err_t                         err_next;
  phase_t                       phase_next;
  logic                         rec_final_next;

  logic                         start;
  logic                         active;
  logic                         e;
  logic [7:0]                   vbuf [LA_CAP];
  logic [7:0]                   sh [LA_CAP];
  logic [LEN_W-1:0]             vcnt;
  logic [LEN_W-1:0]             rl;
  logic [LEN_W-1:0]             fl;
  logic [7:0]                   q;
  mode_t                        mode_eff;

  logic [7:0]                   tb [NTOK][TOK_MAX];
  logic [LEN_W-1:0]             tlen [NTOK];
  logic                         teof [NTOK];
  act_t                         tact [NTOK];
  logic [LEN_W-1:0]             k;
  logic                         pm;
  logic                         full;
  logic [LEN_W:0]               eff;
  logic [LEN_W:0]               best_eff;
  logic [1:0]                   best;
  logic                         possible;
  logic                         m_hit;
  logic                         m_wait;

  logic                         rv;
  kind_t                        r_kind;
  logic [7:0]                   r_byte;
  err_t                         r_code;
  out_item_t                    r_item;
  logic                         done;
  logic                         clear;
  logic [LEN_W-1:0]             drop_n;

  logic [RCNT_W-1:0]            cur_rcnt;
  logic                         keep;
  logic                         flush;
  logic                         advance;

  // token set and longest match over the lookahead window
  always_comb begin
    start  = (phase == PH_IDLE) && q_valid;
    active = start || (phase != PH_IDLE);
    e      = start ? q_item.end_of_input : step_e;
    vcnt   = cnt;
    for (int j = 0; j < LA_CAP; j++) vbuf[j] = la_buf[j];
    if (start && err == ERR_NONE && !q_item.end_of_input && cnt < LEN_W'(LA_CAP)) begin
      for (int j = 0; j < LA_CAP; j++) begin
        if (LEN_W'(j) == cnt) vbuf[j] = q_item.data_byte;
      end
      vcnt = cnt + LEN_W'(1);
    end

    rl = clamp_len(cfg.record_sep_len);
    fl = clamp_len(cfg.field_sep_len);
    q  = cfg.quote_byte;
    mode_eff = (mode == MODE_REC_START || mode == MODE_FIELD_START) ? MODE_UNQUOTED : mode;

    teof[0] = 1'b0;
    teof[1] = 1'b0;
    teof[2] = 1'b1;
    teof[3] = 1'b0;
    if (mode_eff == MODE_QUOTED) begin
      for (int i = 0; i < TOK_MAX; i++) begin
        tb[0][i] = (i == 0) ? q : sep_byte(cfg.record_sep_bytes, i - 1);
        tb[1][i] = (i == 0) ? q : sep_byte(cfg.field_sep_bytes, i - 1);
        tb[2][i] = (i == 0) ? q : 8'h00;
        tb[3][i] = (i < 2) ? q : 8'h00;
      end
      tlen[0] = rl + LEN_W'(1);
      tlen[1] = fl + LEN_W'(1);
      tlen[2] = LEN_W'(1);
      tlen[3] = LEN_W'(2);
      tact[0] = ACT_REC;
      tact[1] = ACT_FLD;
      tact[2] = ACT_REC;
      tact[3] = ACT_QQ;
    end else begin
      for (int i = 0; i < TOK_MAX; i++) begin
        tb[0][i] = sep_byte(cfg.record_sep_bytes, i);
        tb[1][i] = sep_byte(cfg.field_sep_bytes, i);
        tb[2][i] = sep_byte(cfg.field_sep_bytes, i);
        tb[3][i] = (i == 0) ? q : 8'h00;
      end
      tlen[0] = rl;
      tlen[1] = fl;
      tlen[2] = fl;
      tlen[3] = LEN_W'(1);
      tact[0] = ACT_REC;
      tact[1] = ACT_FLD;
      tact[2] = ACT_TRAIL;
      tact[3] = ACT_QERR;
    end

    possible = 1'b0;
    m_hit    = 1'b0;
    best     = 2'd0;
    best_eff = '0;
    k        = '0;
    pm       = 1'b0;
    full     = 1'b0;
    eff      = '0;
    for (int t = 0; t < NTOK; t++) begin
      k  = (vcnt < tlen[t]) ? vcnt : tlen[t];
      pm = 1'b1;
      for (int j = 0; j < TOK_MAX; j++) begin
        if (LEN_W'(j) < k && vbuf[j] != tb[t][j]) pm = 1'b0;
      end
      full = 1'b0;
      if (pm) begin
        if (vcnt < tlen[t]) begin
          if (!e) possible = 1'b1;
        end else if (vcnt == tlen[t]) begin
          if (!teof[t] || e) full = 1'b1;
          else possible = 1'b1;
        end else if (!teof[t]) begin
          full = 1'b1;
        end
      end
      eff = {tlen[t], teof[t]};
      if (full && (!m_hit || eff > best_eff)) begin
        m_hit    = 1'b1;
        best     = 2'(t);
        best_eff = eff;
      end
    end
    m_wait = !e && possible;
  end

  // one parse step per cycle unless the engine is held
  always_comb begin
    rv             = 1'b0;
    r_kind         = KIND_BYTE;
    r_byte         = 8'h00;
    r_code         = ERR_NONE;
    done           = 1'b0;
    clear          = 1'b0;
    drop_n         = '0;
    cnt_next       = vcnt;
    mode_next      = mode;
    fcount_next    = fcount;
    hcount_next    = hcount;
    hpend_next     = hpend;
    err_next       = err;
    phase_next     = PH_RUN;
    rec_final_next = rec_final;
    fcount_inc     = (fcount == {FIELD_COUNT_WIDTH{1'b1}}) ? fcount : fcount + 1'b1;

    if (phase == PH_REC) begin
      if (hpend) begin
        hcount_next = fcount;
        rv          = 1'b1;
        r_kind      = KIND_RECORD;
        hpend_next  = 1'b0;
        fcount_next = '0;
        mode_next   = MODE_REC_START;
      end else if (cfg.count_check_enable && fcount != hcount) begin
        rv       = 1'b1;
        r_kind   = KIND_ERROR;
        r_code   = ERR_COUNT;
        err_next = ERR_COUNT;
        done     = 1'b1;
      end else begin
        rv          = 1'b1;
        r_kind      = KIND_RECORD;
        fcount_next = '0;
        mode_next   = MODE_REC_START;
      end
      if (!done && rec_final) begin
        clear = 1'b1;
        done  = 1'b1;
      end
    end else if (start && err != ERR_NONE) begin
      rv     = 1'b1;
      r_kind = KIND_ERROR;
      r_code = err;
      done   = 1'b1;
    end else if (vcnt == '0) begin
      if (!e) begin
        done = 1'b1;
      end else if (mode == MODE_QUOTED) begin
        rv       = 1'b1;
        r_kind   = KIND_ERROR;
        r_code   = ERR_UNCLOSED;
        err_next = ERR_UNCLOSED;
        done     = 1'b1;
      end else if (mode != MODE_REC_START) begin
        rv             = 1'b1;
        r_kind         = KIND_FIELD;
        fcount_next    = fcount_inc;
        phase_next     = PH_REC;
        rec_final_next = 1'b1;
      end else begin
        clear = 1'b1;
        done  = 1'b1;
      end
    end else if ((mode == MODE_REC_START || mode == MODE_FIELD_START) && vbuf[0] == q) begin
      drop_n    = LEN_W'(1);
      mode_next = MODE_QUOTED;
    end else begin
      mode_next = mode_eff;
      if (m_wait) begin
        done = 1'b1;
      end else if (!m_hit) begin
        rv     = 1'b1;
        r_kind = KIND_BYTE;
        r_byte = vbuf[0];
        drop_n = LEN_W'(1);
      end else begin
        drop_n = tlen[best];
        unique case (tact[best])
          ACT_REC: begin
            rv             = 1'b1;
            r_kind         = KIND_FIELD;
            fcount_next    = fcount_inc;
            phase_next     = PH_REC;
            rec_final_next = teof[best];
          end
          ACT_FLD: begin
            rv          = 1'b1;
            r_kind      = KIND_FIELD;
            fcount_next = fcount_inc;
            mode_next   = MODE_FIELD_START;
          end
          ACT_TRAIL: begin
            rv       = 1'b1;
            r_kind   = KIND_ERROR;
            r_code   = ERR_TRAIL;
            err_next = ERR_TRAIL;
            done     = 1'b1;
          end
          ACT_QERR: begin
            rv       = 1'b1;
            r_kind   = KIND_ERROR;
            r_code   = ERR_QUOTE;
            err_next = ERR_QUOTE;
            done     = 1'b1;
          end
          default: begin
            rv     = 1'b1;
            r_kind = KIND_BYTE;
            r_byte = q;
          end
        endcase
      end
    end

    for (int j = 0; j < LA_CAP; j++) begin
      sh[j] = 8'h00;
      for (int m = 0; m < LA_CAP; m++) begin
        if (m == j + int'(drop_n)) sh[j] = vbuf[m];
      end
    end
    for (int j = 0; j < LA_CAP; j++) buf_next[j] = (drop_n != '0) ? sh[j] : vbuf[j];
    if (drop_n != '0) cnt_next = (drop_n >= vcnt) ? '0 : vcnt - drop_n;

    if (clear) begin
      cnt_next    = '0;
      mode_next   = MODE_REC_START;
      fcount_next = '0;
      hcount_next = '0;
      hpend_next  = 1'b1;
    end
    // nothing buffered and no end mark: the item is finished
    if (!done && phase_next == PH_RUN && cnt_next == '0 && !e) done = 1'b1;
    if (done) phase_next = PH_IDLE;

    r_item = '{kind: r_kind, out_byte: r_byte, error_code: r_code,
               in_header: hpend, last: 1'b0};
  end

  // one result held back until we know whether it ends the item
  always_comb begin
    cur_rcnt   = start ? '0 : rcnt;
    keep       = rv && (cur_rcnt < RCNT_W'(RES_MAX));
    flush      = h_valid && keep && done;
    push_valid = 1'b0;
    push_item  = h_res;
    if (active) begin
      if (flush || (keep && h_valid)) begin
        push_valid     = 1'b1;
        push_item      = h_res;
        push_item.last = 1'b0;
      end else if (done && h_valid) begin
        push_valid     = 1'b1;
        push_item      = h_res;
        push_item.last = 1'b1;
      end else if (done && keep) begin
        push_valid     = 1'b1;
        push_item      = r_item;
        push_item.last = 1'b1;
      end
    end
    advance = active && !flush && (!push_valid || push_ready);
    q_pop   = start && advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      cnt       <= '0;
      mode      <= MODE_REC_START;
      fcount    <= '0;
      hcount    <= '0;
      hpend     <= 1'b1;
      err       <= ERR_NONE;
      step_e    <= 1'b0;
      rec_final <= 1'b0;
      rcnt      <= '0;
      h_valid   <= 1'b0;
    end else begin
      if (flush && push_ready) h_valid <= 1'b0;
      if (advance) begin
        phase     <= phase_next;
        cnt       <= cnt_next;
        mode      <= mode_next;
        fcount    <= fcount_next;
        hcount    <= hcount_next;
        hpend     <= hpend_next;
        err       <= err_next;
        rec_final <= rec_final_next;
        rcnt      <= keep ? cur_rcnt + 1'b1 : cur_rcnt;
        if (start) step_e <= q_item.end_of_input;
        if (keep && !done) h_valid <= 1'b1;
        else if (done) h_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int j = 0; j < LA_CAP; j++) la_buf[j] <= buf_next[j];
      if (keep && !done) h_res <= r_item;
    end
  end

  assign status = '{err: err, busy: (phase != PH_IDLE)};

endmodule
`default_nettype wire

// ===== dv/cft_checker.sv =====
`timescale 1ns / 1ps
module cft_checker
  import cft_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  logic                  item_stall,
  input  in_item_t              item,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  out_item_t             result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  logic [31:0] fsb, rsb;
  logic [2:0]  fsl, rsl;
  logic [7:0]  qb;
  logic        cce;

  logic [7:0]  la [LA_CAP];
  int          la_n;
  mode_t       mode;
  logic [15:0] fcnt, hcnt;
  bit          hpend;
  err_t        err_l;

  out_item_t   res [RES_MAX];
  int          rn;
  out_item_t   tokens_due [$];

  logic [7:0]  tb_b [NTOK][TOK_MAX];
  int          tb_l [NTOK];
  bit          tb_e [NTOK];
  act_t        tb_a [NTOK];

  initial fail_count = 0;
  assign pending = tokens_due.size();

  function automatic int sep_len(logic [2:0] v);
    if (v == 3'd0) return 1;
    if (int'(v) > MAX_SEP_LEN) return MAX_SEP_LEN;
    return int'(v);
  endfunction

  task automatic emit(kind_t k, logic [7:0] b, err_t c);
    if (rn < RES_MAX) res[rn] = '{kind: k, out_byte: b, error_code: c, in_header: hpend, last: 1'b0};
    rn++;
  endtask

  task automatic raise_err(err_t c);
    err_l = c;
    emit(KIND_ERROR, 8'h00, c);
  endtask

  task automatic drop(int k);
    if (k >= la_n) begin
      la_n = 0;
    end else begin
      for (int j = 0; j < la_n - k; j++) la[j] = la[j + k];
      la_n -= k;
    end
  endtask

  task automatic close_field();
    emit(KIND_FIELD, 8'h00, ERR_NONE);
    if (fcnt != 16'hffff) fcnt++;
  endtask

  task automatic close_record();
    if (hpend) begin
      hcnt = fcnt;
      emit(KIND_RECORD, 8'h00, ERR_NONE);
      hpend = 0;
    end else if (cce && fcnt != hcnt) begin
      raise_err(ERR_COUNT);
      return;
    end else begin
      emit(KIND_RECORD, 8'h00, ERR_NONE);
    end
    fcnt = '0;
    mode = MODE_REC_START;
  endtask

  task automatic restart_file();
    la_n = 0;
    mode = MODE_REC_START;
    fcnt = '0;
    hcnt = '0;
    hpend = 1;
  endtask

  task automatic put_sep(int i, int at, logic [31:0] b, int len);
    for (int j = 0; j < len; j++) tb_b[i][at + j] = b[8*j +: 8];
    tb_l[i] = at + len;
  endtask

  // 0 wait, 1 hit, 2 no hit
  function automatic int find_token(bit e, output int which);
    bit possible;
    int best, best_eff, k, eff;
    bit eq, full;
    possible = 0;
    best = -1;
    best_eff = 0;
    which = 0;
    for (int i = 0; i < NTOK; i++) begin
      k = la_n < tb_l[i] ? la_n : tb_l[i];
      eq = 1;
      full = 0;
      for (int j = 0; j < k; j++) if (la[j] != tb_b[i][j]) eq = 0;
      if (!eq) continue;
      if (la_n < tb_l[i]) begin
        if (!e) possible = 1;
      end else if (la_n == tb_l[i]) begin
        if (!tb_e[i] || e) full = 1;
        else possible = 1;
      end else if (!tb_e[i]) begin
        full = 1;
      end
      if (full) begin
        eff = 2 * tb_l[i] + (tb_e[i] ? 1 : 0);
        if (best < 0 || eff > best_eff) begin
          best = i;
          best_eff = eff;
        end
      end
    end
    if (!e && possible) return 0;
    if (best >= 0) begin
      which = best;
      return 1;
    end
    return 2;
  endfunction

  task automatic parse(bit e);
    int fl, rl, which, r;
    fl = sep_len(fsl);
    rl = sep_len(rsl);
    while (err_l == ERR_NONE) begin
      if (la_n == 0) begin
        if (!e) break;
        if (mode == MODE_QUOTED) begin
          raise_err(ERR_UNCLOSED);
          return;
        end
        if (mode != MODE_REC_START) begin
          close_field();
          close_record();
          if (err_l != ERR_NONE) return;
        end
        restart_file();
        return;
      end
      if (mode == MODE_REC_START || mode == MODE_FIELD_START) begin
        if (la[0] == qb) begin
          drop(1);
          mode = MODE_QUOTED;
          continue;
        end
        mode = MODE_UNQUOTED;
      end
      for (int i = 0; i < NTOK; i++) begin
        tb_l[i] = 0;
        tb_e[i] = 0;
        for (int j = 0; j < TOK_MAX; j++) tb_b[i][j] = 8'h00;
      end
      if (mode == MODE_UNQUOTED) begin
        put_sep(0, 0, rsb, rl); tb_a[0] = ACT_REC;
        put_sep(1, 0, fsb, fl); tb_a[1] = ACT_FLD;
        put_sep(2, 0, fsb, fl); tb_e[2] = 1; tb_a[2] = ACT_TRAIL;
        tb_b[3][0] = qb; tb_l[3] = 1; tb_a[3] = ACT_QERR;
      end else begin
        tb_b[0][0] = qb; put_sep(0, 1, rsb, rl); tb_a[0] = ACT_REC;
        tb_b[1][0] = qb; put_sep(1, 1, fsb, fl); tb_a[1] = ACT_FLD;
        tb_b[2][0] = qb; tb_l[2] = 1; tb_e[2] = 1; tb_a[2] = ACT_REC;
        tb_b[3][0] = qb; tb_b[3][1] = qb; tb_l[3] = 2; tb_a[3] = ACT_QQ;
      end
      r = find_token(e, which);
      if (r == 0) break;
      if (r == 2) begin
        emit(KIND_BYTE, la[0], ERR_NONE);
        drop(1);
        continue;
      end
      drop(tb_l[which]);
      case (tb_a[which])
        ACT_REC: begin
          close_field();
          close_record();
          if (err_l == ERR_NONE && tb_e[which]) begin
            restart_file();
            return;
          end
        end
        ACT_FLD: begin
          close_field();
          mode = MODE_FIELD_START;
        end
        ACT_TRAIL: begin
          raise_err(ERR_TRAIL);
          return;
        end
        ACT_QERR: begin
          raise_err(ERR_QUOTE);
          return;
        end
        default: emit(KIND_BYTE, qb, ERR_NONE);
      endcase
    end
  endtask

  task automatic predict_item(in_item_t it);
    int n;
    rn = 0;
    if (err_l != ERR_NONE) begin
      emit(KIND_ERROR, 8'h00, err_l);
    end else begin
      if (!it.end_of_input && la_n < LA_CAP) begin
        la[la_n] = it.data_byte;
        la_n++;
      end
      parse(it.end_of_input);
    end
    n = rn > RES_MAX ? RES_MAX : rn;
    if (n > 0) res[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) tokens_due.push_back(res[i]);
  endtask

  task automatic report(string what, int got, int want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (tokens_due.size() == 0) begin
      report("unexpected item", int'(got), 0);
      return;
    end
    want = tokens_due.pop_front();
    if (got.kind != want.kind) report("kind", int'(got.kind), int'(want.kind));
    if (got.out_byte != want.out_byte)
      report("out_byte", int'(got.out_byte), int'(want.out_byte));
    if (got.error_code != want.error_code)
      report("error_code", int'(got.error_code), int'(want.error_code));
    if (got.in_header != want.in_header)
      report("in_header", int'(got.in_header), int'(want.in_header));
    if (got.last != want.last) report("last", int'(got.last), int'(want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fsb = 32'd44; fsl = 3'd1; rsb = 32'd10; rsl = 3'd1; qb = 8'd34; cce = 1'b1;
      restart_file();
      err_l = ERR_NONE;
      tokens_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIELD_SEP_BYTES:  fsb = cfg_data;
          CFG_FIELD_SEP_LEN:    fsl = cfg_data[2:0];
          CFG_RECORD_SEP_BYTES: rsb = cfg_data;
          CFG_RECORD_SEP_LEN:   rsl = cfg_data[2:0];
          CFG_QUOTE_BYTE:       qb = cfg_data[7:0];
          CFG_COUNT_CHECK:      cce = cfg_data[0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) predict_item(item);
      if (result_valid && !result_stall) check_result(result);
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import cft_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  in_item_t              item = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  out_item_t             result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count, pending;

  int tx_idle = 0, rx_idle = 0, idle_cycles = 0, sent = 0;
  bit drain = 0;

  logic [31:0] c_fsb = 32'd44, c_rsb = 32'd10;
  logic [2:0]  c_fsl = 3'd1, c_rsl = 3'd1;
  logic [7:0]  c_q = 8'd34;
  logic        c_cc = 1'b1;
  int          file_fields;

  csv_field_tokenizer i_dut (
    .clk, .rst, .item_valid, .item_stall, .item,
    .result_valid, .result_stall, .result, .cfg_we, .cfg_index, .cfg_data
  );

  cft_checker i_checker (
    .clk, .rst, .item_valid, .item_stall, .item,
    .result_valid, .result_stall, .result, .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) result_stall <= !drain && ($urandom_range(99) < rx_idle);

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == 2000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int sep_len(logic [2:0] v);
    if (v == 3'd0) return 1;
    if (int'(v) > MAX_SEP_LEN) return MAX_SEP_LEN;
    return int'(v);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    bit bad;
    do begin
      b = 8'($urandom_range(255));
      bad = (b == c_q);
      for (int j = 0; j < sep_len(c_fsl); j++) if (b == c_fsb[8*j +: 8]) bad = 1;
      for (int j = 0; j < sep_len(c_rsl); j++) if (b == c_rsb[8*j +: 8]) bad = 1;
    end while (bad);
    return b;
  endfunction

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < tx_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item('{data_byte: b, end_of_input: 1'b0});
  endtask

  task automatic send_eof();
    send_item('{data_byte: 8'($urandom_range(255)), end_of_input: 1'b1});
  endtask

  task automatic send_sep(logic [31:0] b, logic [2:0] len);
    for (int j = 0; j < sep_len(len); j++) send_byte(b[8*j +: 8]);
  endtask

  task automatic send_field();
    int n;
    n = $urandom_range(3) == 0 ? $urandom_range(8) : $urandom_range(3);
    if ($urandom_range(2) == 0) begin
      send_byte(c_q);
      send_byte(plain_byte());
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(4) == 0) begin
          send_byte(c_q);
          send_byte(c_q);
        end else begin
          send_byte(plain_byte());
        end
      end
      send_byte(c_q);
    end else begin
      for (int i = 0; i < n; i++) send_byte(plain_byte());
    end
  endtask

  task automatic send_fields(int nf);
    for (int i = 0; i < nf; i++) begin
      send_field();
      if (i < nf - 1) send_sep(c_fsb, c_fsl);
    end
  endtask

  task automatic send_record(int nf);
    send_fields(nf);
    send_sep(c_rsb, c_rsl);
  endtask

  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 8)) begin
      do b = 8'($urandom_range(255)); while (b == c_q);
      send_byte(b);
    end
    send_byte(plain_byte());
    send_sep(c_rsb, c_rsl);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
  endtask

  task automatic wait_quiet();
    item_valid <= 1'b0;
    drain = 1;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(int ph);
    case (ph)
      0: begin
        c_fsb = 32'h0000_002c; c_fsl = 3'd0; c_rsb = 32'h0000_000a; c_rsl = 3'd1;
        c_q = 8'h22; c_cc = 1'b1;
      end
      1: begin
        c_fsb = 32'h0000_7c7c; c_fsl = 3'd2; c_rsb = 32'h0000_0a0d; c_rsl = 3'd2;
        c_q = 8'hff; c_cc = 1'b0;
      end
      default: begin
        c_fsb = 32'h3b3a_3b3a; c_fsl = 3'd4; c_rsb = 32'h0d0a_0d0a; c_rsl = 3'd7;
        c_q = 8'h00; c_cc = 1'b1;
      end
    endcase
    wait_quiet();
    write_reg(CFG_FIELD_SEP_BYTES, c_fsb);
    write_reg(CFG_FIELD_SEP_LEN, 32'(c_fsl));
    write_reg(CFG_RECORD_SEP_BYTES, c_rsb);
    write_reg(CFG_RECORD_SEP_LEN, 32'(c_rsl));
    write_reg(CFG_QUOTE_BYTE, 32'(c_q));
    write_reg(CFG_COUNT_CHECK, 32'(c_cc));
    cfg_we <= 1'b0;
    drain = 0;
  endtask

  task automatic send_directed();
    logic [7:0] seq [$];
    seq = '{8'h00, 8'hff, ",", "\"", "a", ",", "\"", "\"", "b", "\"", ",", "\n",
            "x", ",", ",", "y"};
    foreach (seq[i]) send_byte(seq[i]);
    send_eof();
    send_eof();
  endtask

  task automatic send_random(int count);
    int start, r;
    start = sent;
    file_fields = $urandom_range(1, 4);
    while (sent - start < count) begin
      r = $urandom_range(9);
      if (r == 7) begin
        send_fields(file_fields);
        send_eof();
        file_fields = $urandom_range(1, 4);
      end else if (r == 8) begin
        send_eof();
        file_fields = $urandom_range(1, 4);
      end else if (r == 9 && !c_cc) begin
        send_noise();
      end else begin
        send_record(c_cc ? file_fields : $urandom_range(1, 5));
      end
    end
  endtask

  task automatic send_error_case();
    case ($urandom_range(3))
      0: begin
        send_byte(plain_byte());
        send_sep(c_fsb, c_fsl);
        send_eof();
      end
      1: begin
        send_byte(plain_byte());
        send_byte(c_q);
      end
      2: begin
        send_byte(c_q);
        send_byte(plain_byte());
        send_eof();
      end
      default: begin
        send_record(file_fields);
        send_record(file_fields + 1);
      end
    endcase
    repeat (3) send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = ph == 0 ? 38 : (ph == 1 ? 49 : 0);
      rx_idle = ph == 0 ? 49 : (ph == 1 ? 38 : 0);
      configure(ph);
      if (ph == 0) send_directed();
      send_random(ph == 0 ? 30 : 45);
      if (ph == 2) send_error_case();
      else send_eof();
    end
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/cft_pkg.sv
rtl/core/cft_front.sv
rtl/core/cft_engine.sv
rtl/core/csv_field_tokenizer.sv
dv/cft_checker.sv
dv/tb_top.sv
